@@ sv/i2c_rts_pkg.sv @@
// shared types, constants and helpers for the i2c register transfer sequencer
// no dependencies
package i2c_rts_pkg;

  localparam int OpW     = 2;
  localparam int DevW    = 7;
  localparam int ByteW   = 8;
  localparam int FlagW   = 5;
  localparam int ActW    = 3;
  localparam int StatW   = 4;
  localparam int PhaseW  = 4;
  localparam int CountW  = 24;
  localparam int MaxRes  = 3;
  localparam int ResIdxW = 2;

  localparam logic [CountW-1:0] TimeoutReset = CountW'(100000);

  localparam logic [OpW-1:0] OP_POLL  = 2'd0;
  localparam logic [OpW-1:0] OP_WRITE = 2'd1;
  localparam logic [OpW-1:0] OP_READ  = 2'd2;

  localparam int FL_SB   = 0;
  localparam int FL_ADDR = 1;
  localparam int FL_BTF  = 2;
  localparam int FL_TXE  = 3;
  localparam int FL_RXNE = 4;

  localparam logic [PhaseW-1:0] PH_IDLE  = 4'd0;
  localparam logic [PhaseW-1:0] PH_SB    = 4'd1;
  localparam logic [PhaseW-1:0] PH_ADDR  = 4'd2;
  localparam logic [PhaseW-1:0] PH_REG   = 4'd3;
  localparam logic [PhaseW-1:0] PH_TXE   = 4'd4;
  localparam logic [PhaseW-1:0] PH_FIN   = 4'd5;
  localparam logic [PhaseW-1:0] PH_RSB   = 4'd6;
  localparam logic [PhaseW-1:0] PH_RADDR = 4'd7;
  localparam logic [PhaseW-1:0] PH_RX    = 4'd8;

  localparam logic [ActW-1:0] ACT_START  = 3'd0;
  localparam logic [ActW-1:0] ACT_WRITE  = 3'd1;
  localparam logic [ActW-1:0] ACT_CLRACK = 3'd2;
  localparam logic [ActW-1:0] ACT_SETACK = 3'd3;
  localparam logic [ActW-1:0] ACT_RECV   = 3'd4;
  localparam logic [ActW-1:0] ACT_STOP   = 3'd5;
  localparam logic [ActW-1:0] ACT_ABORT  = 3'd6;

  localparam logic [StatW-1:0] ST_OK = 4'd0;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [DevW-1:0]  device_address;
    logic [ByteW-1:0] register_address;
    logic [ByteW-1:0] transfer_length;
    logic [FlagW-1:0] bus_flags;
    logic [ByteW-1:0] rx_byte;
    logic [ByteW-1:0] tx_byte;
  } item_t;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [ByteW-1:0] byte_value;
    logic [StatW-1:0] status;
  } result_t;

  typedef struct packed {
    logic [ResIdxW-1:0]       count;
    result_t [MaxRes-1:0]     res;
  } bundle_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [CountW-1:0] countdown;
    logic [ByteW-1:0]  bytes_done;
    logic [ByteW-1:0]  bytes_total;
    logic [DevW-1:0]   target_device;
    logic [ByteW-1:0]  target_register;
    logic              read_mode;
  } seq_state_t;

  function automatic result_t mk_res(logic [ActW-1:0] act, logic [ByteW-1:0] val,
                                     logic [StatW-1:0] st);
    result_t r;
    r.action     = act;
    r.byte_value = val;
    r.status     = st;
    return r;
  endfunction

endpackage

@@ sv/i2c_rts_channels.sv @@
// valid/ready channel interfaces: item input, result output, config write
// depends on i2c_rts_pkg
interface i2c_rts_req_if import i2c_rts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   opcode;
  logic [DevW-1:0]  device_address;
  logic [ByteW-1:0] register_address;
  logic [ByteW-1:0] transfer_length;
  logic [FlagW-1:0] bus_flags;
  logic [ByteW-1:0] rx_byte;
  logic [ByteW-1:0] tx_byte;

  modport source (output valid, opcode, device_address, register_address, transfer_length,
                  bus_flags, rx_byte, tx_byte, input ready);
  modport sink (input valid, opcode, device_address, register_address, transfer_length,
                bus_flags, rx_byte, tx_byte, output ready);
endinterface

interface i2c_rts_rsp_if import i2c_rts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ActW-1:0]  action;
  logic [ByteW-1:0] byte_value;
  logic [StatW-1:0] status;
  logic             last;

  modport source (output valid, action, byte_value, status, last, input ready);
  modport sink (input valid, action, byte_value, status, last, output ready);
endinterface

interface i2c_rts_cfg_if import i2c_rts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ sv/i2c_rts_step.sv @@
// next-state and result logic for one item of the sequencer
// depends on i2c_rts_pkg
module i2c_rts_step import i2c_rts_pkg::*; (
  input  item_t             item,
  input  seq_state_t        cur,
  input  logic [CountW-1:0] timeout_limit,
  output seq_state_t        nxt,
  output bundle_t           bundle
);

  logic need_ok;
  logic phase_known;
  logic rx_final;

  assign rx_final = ({1'b0, cur.bytes_done} + (ByteW+1)'(1)) >= {1'b0, cur.bytes_total};

  always_comb begin
    nxt         = cur;
    bundle      = '0;
    need_ok     = 1'b0;
    phase_known = 1'b1;
    case (cur.phase)
      PH_SB, PH_RSB:     need_ok = item.bus_flags[FL_SB];
      PH_ADDR, PH_RADDR: need_ok = item.bus_flags[FL_ADDR];
      PH_REG, PH_FIN:    need_ok = item.bus_flags[FL_BTF];
      PH_TXE:            need_ok = item.bus_flags[FL_TXE];
      PH_RX:             need_ok = item.bus_flags[FL_RXNE];
      default:           phase_known = 1'b0;
    endcase

    if (item.opcode inside {OP_WRITE, OP_READ}) begin
      if (cur.phase == PH_IDLE) begin
        nxt.target_device   = item.device_address;
        nxt.target_register = item.register_address;
        nxt.bytes_total     = item.transfer_length;
        nxt.bytes_done      = '0;
        nxt.read_mode       = (item.opcode == OP_READ);
        nxt.countdown       = timeout_limit;
        nxt.phase           = PH_SB;
        bundle.count        = ResIdxW'(1);
        bundle.res[0]       = mk_res(ACT_START, '0, ST_OK);
      end
    end else if (item.opcode == OP_POLL && cur.phase != PH_IDLE) begin
      if (!phase_known) begin
        nxt.phase = PH_IDLE;
      end else if (!need_ok) begin
        if (cur.countdown <= CountW'(1)) begin
          nxt.countdown = '0;
          nxt.phase     = PH_IDLE;
          bundle.count  = ResIdxW'(1);
          bundle.res[0] = mk_res(ACT_ABORT, '0, cur.phase);
        end else begin
          nxt.countdown = cur.countdown - CountW'(1);
        end
      end else begin
        case (cur.phase)
          PH_SB: begin
            bundle.count  = ResIdxW'(1);
            bundle.res[0] = mk_res(ACT_WRITE, {cur.target_device, 1'b0}, ST_OK);
            nxt.phase     = PH_ADDR;
          end
          PH_ADDR: begin
            bundle.count  = ResIdxW'(1);
            bundle.res[0] = mk_res(ACT_WRITE, cur.target_register, ST_OK);
            nxt.phase     = PH_REG;
          end
          PH_REG: begin
            if (cur.read_mode) begin
              bundle.count  = ResIdxW'(1);
              bundle.res[0] = mk_res(ACT_START, '0, ST_OK);
              nxt.phase     = PH_RSB;
            end else if (cur.bytes_total != '0) begin
              bundle.count   = ResIdxW'(1);
              bundle.res[0]  = mk_res(ACT_WRITE, item.tx_byte, ST_OK);
              nxt.bytes_done = ByteW'(1);
              nxt.phase      = PH_TXE;
            end else begin
              nxt.phase = PH_FIN;
            end
          end
          PH_TXE: begin
            if (cur.bytes_done < cur.bytes_total) begin
              bundle.count   = ResIdxW'(1);
              bundle.res[0]  = mk_res(ACT_WRITE, item.tx_byte, ST_OK);
              nxt.bytes_done = cur.bytes_done + ByteW'(1);
            end else begin
              nxt.phase = PH_FIN;
            end
          end
          PH_FIN: begin
            bundle.count  = ResIdxW'(1);
            bundle.res[0] = mk_res(ACT_STOP, '0, ST_OK);
            nxt.phase     = PH_IDLE;
          end
          PH_RSB: begin
            bundle.count  = ResIdxW'(1);
            bundle.res[0] = mk_res(ACT_WRITE, {cur.target_device, 1'b1}, ST_OK);
            nxt.phase     = PH_RADDR;
          end
          PH_RADDR: begin
            if (cur.bytes_total == '0) begin
              bundle.count  = ResIdxW'(1);
              bundle.res[0] = mk_res(ACT_STOP, '0, ST_OK);
              nxt.phase     = PH_IDLE;
            end else begin
              nxt.phase = PH_RX;
            end
          end
          default: begin
            bundle.count  = ResIdxW'(3);
            bundle.res[1] = mk_res(ACT_RECV, item.rx_byte, ST_OK);
            if (rx_final) begin
              bundle.res[0]  = mk_res(ACT_CLRACK, '0, ST_OK);
              bundle.res[2]  = mk_res(ACT_STOP, '0, ST_OK);
              nxt.bytes_done = cur.bytes_total;
              nxt.phase      = PH_IDLE;
            end else begin
              bundle.res[0]  = mk_res(ACT_SETACK, '0, ST_OK);
              bundle.count   = ResIdxW'(2);
              nxt.bytes_done = cur.bytes_done + ByteW'(1);
            end
          end
        endcase
      end
    end
  end

endmodule

@@ sv/i2c_rts_drain.sv @@
// result register: holds the results of one item and hands them out one per transfer
// depends on i2c_rts_pkg and i2c_rts_rsp_if
module i2c_rts_drain import i2c_rts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  bundle_t bundle,
  output logic    can_load,
  i2c_rts_rsp_if.source rsp
);

  logic               valid;
  logic [ResIdxW-1:0] ptr;
  logic [ResIdxW-1:0] count;
  result_t [MaxRes-1:0] res;
  logic               at_last;
  result_t            cur_res;

  assign at_last  = (ptr == count - ResIdxW'(1));
  assign can_load = !valid || (rsp.ready && at_last);
  assign cur_res  = res[ptr];

  assign rsp.valid      = valid;
  assign rsp.action     = cur_res.action;
  assign rsp.byte_value = cur_res.byte_value;
  assign rsp.status     = cur_res.status;
  assign rsp.last       = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      ptr   <= '0;
      count <= '0;
    end else if (load) begin
      valid <= 1'b1;
      ptr   <= '0;
      count <= bundle.count;
    end else if (valid && rsp.ready) begin
      if (at_last) begin
        valid <= 1'b0;
      end else begin
        ptr <= ptr + ResIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= bundle.res;
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (ptr < count))
    else $error("result pointer beyond stored count");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> can_load)
    else $error("results loaded over undelivered ones");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> (valid && ptr == '0))
    else $error("loaded results not presented from the first");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (valid && !rsp.ready) |=> (valid && $stable(ptr)))
    else $error("result moved while stalled");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (valid && rsp.ready && at_last && !load) |=> !valid)
    else $error("result register not freed after last transfer");

endmodule

@@ sv/i2c_register_transfer_sequencer_unit.sv @@
// i2c master register write/read sequencer, top level
// depends on i2c_rts_pkg, i2c_rts_channels, i2c_rts_step, i2c_rts_drain
// An item is accepted whenever the result register is free or frees in the same cycle, so
// begin and poll items go in at one per clock; each item's results appear in the result
// register the cycle after its transfer. Most items give zero or one result; a received byte
// gives two (set ack, byte) or three (clear ack, byte, stop), and the result register then
// holds the input back while it hands them out one per transfer. The timeout register can
// be written at any time through cfg and is loaded into the countdown at the next begin.
module i2c_register_transfer_sequencer_unit import i2c_rts_pkg::*; (
  input logic clk,
  input logic rst,
  i2c_rts_cfg_if.sink   cfg,
  i2c_rts_req_if.sink   req,
  i2c_rts_rsp_if.source rsp
);

  logic [CountW-1:0] timeout_limit;
  logic [PhaseW-1:0] phase;
  logic [CountW-1:0] countdown;
  logic [ByteW-1:0]  bytes_done;
  logic              read_mode;
  logic [ByteW-1:0]  bytes_total;
  logic [DevW-1:0]   target_device;
  logic [ByteW-1:0]  target_register;

  seq_state_t cur;
  seq_state_t nxt;
  item_t      item;
  bundle_t    bundle;
  logic       can_load;
  logic       accept;
  logic       load;

  assign cfg.ready = 1'b1;
  assign req.ready = can_load;
  assign accept    = req.valid && can_load;
  assign load      = accept && (bundle.count != '0);

  assign item.opcode           = req.opcode;
  assign item.device_address   = req.device_address;
  assign item.register_address = req.register_address;
  assign item.transfer_length  = req.transfer_length;
  assign item.bus_flags        = req.bus_flags;
  assign item.rx_byte          = req.rx_byte;
  assign item.tx_byte          = req.tx_byte;

  assign cur.phase           = phase;
  assign cur.countdown       = countdown;
  assign cur.bytes_done      = bytes_done;
  assign cur.bytes_total     = bytes_total;
  assign cur.target_device   = target_device;
  assign cur.target_register = target_register;
  assign cur.read_mode       = read_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TimeoutReset;
    end else if (cfg.valid) begin
      timeout_limit <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      countdown  <= '0;
      bytes_done <= '0;
      read_mode  <= 1'b0;
    end else if (accept) begin
      phase      <= nxt.phase;
      countdown  <= nxt.countdown;
      bytes_done <= nxt.bytes_done;
      read_mode  <= nxt.read_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bytes_total     <= nxt.bytes_total;
      target_device   <= nxt.target_device;
      target_register <= nxt.target_register;
    end
  end

  i2c_rts_step u_step (
    .item          (item),
    .cur           (cur),
    .timeout_limit (timeout_limit),
    .nxt           (nxt),
    .bundle        (bundle)
  );

  i2c_rts_drain u_drain (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .bundle   (bundle),
    .can_load (can_load),
    .rsp      (rsp)
  );

endmodule

@@ verif/i2c_register_transfer_sequencer_unit_tb.sv @@
// self-checking testbench for the i2c register transfer sequencer: a directed table,
// then random transfers under several timeout settings, checked against a local model
// depends on i2c_rts_pkg, i2c_rts_channels and i2c_register_transfer_sequencer_unit
module i2c_register_transfer_sequencer_unit_tb import i2c_rts_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OpW-1:0]   OP_UNUSED        = 2'd3;
  localparam logic [StatW-1:0] ST_START_TIMEOUT = 4'd1;
  localparam int               IdleLimit        = 2000;
  localparam int               DrainCycles      = 8;
  localparam int               FirstTimeoutRow  = 21;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [ByteW-1:0] byte_value;
    logic [StatW-1:0] status;
    logic             last;
  } outcome_t;

  typedef struct {
    item_t    it;
    int       n_typed;
    outcome_t typed;
  } stim_row_t;

  logic clk;
  logic rst;

  i2c_rts_cfg_if cfg ();
  i2c_rts_req_if req ();
  i2c_rts_rsp_if rsp ();

  i2c_register_transfer_sequencer_unit i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

  logic [CountW-1:0] timeout_limit;
  logic [PhaseW-1:0] seq_phase;
  logic [CountW-1:0] countdown;
  logic [ByteW-1:0]  bytes_done;
  logic [ByteW-1:0]  bytes_total;
  logic [DevW-1:0]   target_dev;
  logic [ByteW-1:0]  target_reg;
  logic              read_mode;

  outcome_t step_outcomes[$];
  outcome_t pending_outcomes[$];

  bit failed;
  bit quiet;
  bit send_calm;
  int items_driven;
  int idle_cycles;

  stim_row_t directed_rows[23] = '{
    '{'{OP_POLL,   7'h00, 8'h00, 8'h00, 5'h1F, 8'h00, 8'h00}, 0, '0},
    '{'{OP_UNUSED, 7'h7F, 8'hFF, 8'hFF, 5'h1F, 8'hFF, 8'hFF}, 0, '0},
    '{'{OP_WRITE,  7'h7F, 8'hFF, 8'h01, 5'h00, 8'h00, 8'h00}, 1,
      '{ACT_START, 8'h00, ST_OK, 1'b1}},
    '{'{OP_READ,   7'h00, 8'h00, 8'hFF, 5'h00, 8'h00, 8'h00}, 0, '0},
    '{'{OP_POLL,   7'h00, 8'h00, 8'h00, 5'h1E, 8'hFF, 8'hFF}, 0, '0},
    '{'{OP_POLL,   7'h00, 8'h00, 8'h00, 5'h01, 8'h00, 8'h00}, 1,
      '{ACT_WRITE, 8'hFE, ST_OK, 1'b1}},
    '{'{OP_POLL,   7'h00, 8'h00, 8'h00, 5'h1F, 8'h00, 8'h00}, 1,
      '{ACT_WRITE, 8'hFF, ST_OK, 1'b1}},
    '{'{OP_POLL,   7'h00, 8'h00, 8'h00, 5'h04, 8'h00, 8'hA5}, 1,
      '{ACT_WRITE, 8'hA5, ST_OK, 1'b1}},
    '{'{OP_POLL,   7'h00, 8'h00, 8'h00, 5'h1F, 8'h00, 8'h3C}, 0, '0},
    '{'{OP_POLL,   7'h00, 8'h00, 8'h00, 5'h04, 8'h00, 8'h00}, 1,
      '{ACT_STOP, 8'h00, ST_OK, 1'b1}},
    '{'{OP_WRITE,  7'h00, 8'h00, 8'h00, 5'h00, 8'h00, 8'h00}, 1,
      '{ACT_START, 8'h00, ST_OK, 1'b1}},
    '{'{OP_POLL,   7'h00, 8'h00, 8'h00, 5'h01, 8'h00, 8'h00}, -1, '0},
    '{'{OP_POLL,   7'h00, 8'h00, 8'h00, 5'h02, 8'h00, 8'h00}, -1, '0},
    '{'{OP_POLL,   7'h00, 8'h00, 8'h00, 5'h04, 8'h00, 8'hFF}, -1, '0},
    '{'{OP_POLL,   7'h00, 8'h00, 8'h00, 5'h1F, 8'h00, 8'h00}, 1,
      '{ACT_STOP, 8'h00, ST_OK, 1'b1}},
    '{'{OP_READ,   7'h55, 8'h10, 8'h00, 5'h00, 8'h00, 8'h00}, 1,
      '{ACT_START, 8'h00, ST_OK, 1'b1}},
    '{'{OP_POLL,   7'h00, 8'h00, 8'h00, 5'h01, 8'h00, 8'h00}, -1, '0},
    '{'{OP_POLL,   7'h00, 8'h00, 8'h00, 5'h02, 8'h00, 8'h00}, -1, '0},
    '{'{OP_POLL,   7'h00, 8'h00, 8'h00, 5'h04, 8'h00, 8'h00}, -1, '0},
    '{'{OP_POLL,   7'h00, 8'h00, 8'h00, 5'h01, 8'h00, 8'h00}, -1, '0},
    '{'{OP_POLL,   7'h00, 8'h00, 8'h00, 5'h02, 8'h00, 8'h00}, 1,
      '{ACT_STOP, 8'h00, ST_OK, 1'b1}},
    '{'{OP_WRITE,  7'h2A, 8'h80, 8'hFF, 5'h00, 8'h00, 8'h00}, 1,
      '{ACT_START, 8'h00, ST_OK, 1'b1}},
    '{'{OP_POLL,   7'h00, 8'h00, 8'h00, 5'h1E, 8'h00, 8'h00}, 1,
      '{ACT_ABORT, 8'h00, ST_START_TIMEOUT, 1'b1}}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [FlagW-1:0] phase_flag(input logic [PhaseW-1:0] p);
    case (p)
      PH_SB, PH_RSB:    return FlagW'(1) << FL_SB;
      PH_ADDR, PH_RADDR: return FlagW'(1) << FL_ADDR;
      PH_REG, PH_FIN:   return FlagW'(1) << FL_BTF;
      PH_TXE:           return FlagW'(1) << FL_TXE;
      PH_RX:            return FlagW'(1) << FL_RXNE;
      default:          return '0;
    endcase
  endfunction

  function automatic void emit(input logic [ActW-1:0] act, input logic [ByteW-1:0] val,
                               input logic [StatW-1:0] st);
    step_outcomes.push_back('{act, val, st, 1'b0});
  endfunction

  function automatic void advance_transfer(input item_t it);
    step_outcomes.delete();
    if (it.opcode == OP_WRITE || it.opcode == OP_READ) begin
      if (seq_phase == PH_IDLE) begin
        target_dev  = it.device_address;
        target_reg  = it.register_address;
        bytes_total = it.transfer_length;
        bytes_done  = '0;
        read_mode   = (it.opcode == OP_READ);
        countdown   = timeout_limit;
        seq_phase   = PH_SB;
        emit(ACT_START, '0, ST_OK);
      end
    end else if (it.opcode == OP_POLL && seq_phase != PH_IDLE) begin
      if ((it.bus_flags & phase_flag(seq_phase)) == '0) begin
        if (countdown <= 1) begin
          countdown = '0;
          emit(ACT_ABORT, '0, StatW'(seq_phase));
          seq_phase = PH_IDLE;
        end else begin
          countdown = countdown - 1'b1;
        end
      end else begin
        case (seq_phase)
          PH_SB: begin
            emit(ACT_WRITE, {target_dev, 1'b0}, ST_OK);
            seq_phase = PH_ADDR;
          end
          PH_ADDR: begin
            emit(ACT_WRITE, target_reg, ST_OK);
            seq_phase = PH_REG;
          end
          PH_REG: begin
            if (read_mode) begin
              emit(ACT_START, '0, ST_OK);
              seq_phase = PH_RSB;
            end else if (bytes_total != 0) begin
              emit(ACT_WRITE, it.tx_byte, ST_OK);
              bytes_done = 8'd1;
              seq_phase  = PH_TXE;
            end else begin
              seq_phase = PH_FIN;
            end
          end
          PH_TXE: begin
            if (bytes_done < bytes_total) begin
              emit(ACT_WRITE, it.tx_byte, ST_OK);
              bytes_done = bytes_done + 1'b1;
            end else begin
              seq_phase = PH_FIN;
            end
          end
          PH_FIN: begin
            emit(ACT_STOP, '0, ST_OK);
            seq_phase = PH_IDLE;
          end
          PH_RSB: begin
            emit(ACT_WRITE, {target_dev, 1'b1}, ST_OK);
            seq_phase = PH_RADDR;
          end
          PH_RADDR: begin
            if (bytes_total == 0) begin
              emit(ACT_STOP, '0, ST_OK);
              seq_phase = PH_IDLE;
            end else begin
              seq_phase = PH_RX;
            end
          end
          default: begin
            if (int'(bytes_done) + 1 >= int'(bytes_total)) begin
              emit(ACT_CLRACK, '0, ST_OK);
              emit(ACT_RECV, it.rx_byte, ST_OK);
              emit(ACT_STOP, '0, ST_OK);
              bytes_done = bytes_total;
              seq_phase  = PH_IDLE;
            end else begin
              emit(ACT_SETACK, '0, ST_OK);
              emit(ACT_RECV, it.rx_byte, ST_OK);
              bytes_done = bytes_done + 1'b1;
            end
          end
        endcase
      end
    end
    if (step_outcomes.size() > 0) step_outcomes[$].last = 1'b1;
  endfunction

  task automatic send_item(input item_t it, input int n_typed, input outcome_t typed);
    if (items_driven % 30 == 0) send_calm = ($urandom_range(0, 2) == 0);
    items_driven++;
    if (!quiet && !send_calm && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req.valid <= 1'b1;
    {req.opcode, req.device_address, req.register_address, req.transfer_length,
     req.bus_flags, req.rx_byte, req.tx_byte} <= it;
    do @(posedge clk); while (!req.ready);
    advance_transfer(it);
    if (n_typed < 0) begin
      foreach (step_outcomes[k]) pending_outcomes.push_back(step_outcomes[k]);
    end else if (n_typed == 1) begin
      pending_outcomes.push_back(typed);
    end
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [CountW-1:0] value);
    drain_results();
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    timeout_limit = value;
  endtask

  task automatic run_random(input int n_items);
    item_t            it;
    int               sent;
    bit               ignored;
    logic [FlagW-1:0] need;
    sent = 0;
    while (sent < n_items) begin
      it.device_address   = DevW'($urandom_range(0, 127));
      it.register_address = ByteW'($urandom_range(0, 255));
      it.transfer_length  = ByteW'($urandom_range(0, 255));
      it.bus_flags        = FlagW'($urandom_range(0, 31));
      it.rx_byte          = ByteW'($urandom_range(0, 255));
      it.tx_byte          = ByteW'($urandom_range(0, 255));
      if (seq_phase == PH_IDLE) begin
        case ($urandom_range(0, 9))
          0:       it.opcode = OP_POLL;
          1:       it.opcode = OP_UNUSED;
          default: it.opcode = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
        endcase
        if (timeout_limit > 50 || $urandom_range(0, 4) != 0)
          it.transfer_length = ByteW'($urandom_range(0, 3));
        ignored = (it.opcode != OP_WRITE && it.opcode != OP_READ);
      end else begin
        case ($urandom_range(0, 19))
          0:       it.opcode = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
          1:       it.opcode = OP_UNUSED;
          default: it.opcode = OP_POLL;
        endcase
        need = phase_flag(seq_phase);
        if ($urandom_range(0, 4) != 0) it.bus_flags = it.bus_flags | need;
        else it.bus_flags = it.bus_flags & ~need;
        ignored = (it.opcode != OP_POLL);
      end
      send_item(it, -1, '0);
      if (!ignored) sent++;
    end
  endtask

  initial begin : rsp_backpressure
    int  hold;
    int  window;
    bit  calm;
    rsp.ready = 1'b0;
    hold   = 0;
    window = 0;
    calm   = 1'b0;
    forever begin
      @(posedge clk);
      if (window == 0) begin
        calm   = ($urandom_range(0, 2) == 0);
        window = 40;
      end
      window--;
      if (quiet || calm) begin
        rsp.ready <= 1'b1;
      end else if (hold > 0) begin
        rsp.ready <= 1'b0;
        hold--;
      end else if ($urandom_range(0, 3) == 0) begin
        rsp.ready <= 1'b0;
        hold = $urandom_range(0, 2);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (pending_outcomes.size() == 0) begin
          $error("unexpected result: action %0d byte_value %0h status %0d last %0b",
                 rsp.action, rsp.byte_value, rsp.status, rsp.last);
          failed = 1'b1;
        end else begin
          want = pending_outcomes.pop_front();
          if (rsp.action !== want.action) begin
            $error("action mismatch: expected %0d, got %0d", want.action, rsp.action);
            failed = 1'b1;
          end
          if (rsp.byte_value !== want.byte_value) begin
            $error("byte_value mismatch: expected %0h, got %0h", want.byte_value,
                   rsp.byte_value);
            failed = 1'b1;
          end
          if (rsp.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, rsp.status);
            failed = 1'b1;
          end
          if (rsp.last !== want.last) begin
            $error("last mismatch: expected %0b, got %0b", want.last, rsp.last);
            failed = 1'b1;
          end
        end
      end
      if ((rsp.valid && rsp.ready) || (req.valid && req.ready) || (cfg.valid && cfg.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : main_seq
    rst       = 1'b1;
    req.valid = 1'b0;
    {req.opcode, req.device_address, req.register_address, req.transfer_length,
     req.bus_flags, req.rx_byte, req.tx_byte} = '0;
    cfg.valid = 1'b0;
    cfg.data  = '0;
    failed       = 1'b0;
    quiet        = 1'b0;
    send_calm    = 1'b0;
    items_driven = 0;
    idle_cycles  = 0;
    timeout_limit = TimeoutReset;
    seq_phase     = PH_IDLE;
    countdown     = '0;
    bytes_done    = '0;
    bytes_total   = '0;
    target_dev    = '0;
    target_reg    = '0;
    read_mode     = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (i == FirstTimeoutRow) write_timeout(CountW'(1));
      send_item(directed_rows[i].it, directed_rows[i].n_typed, directed_rows[i].typed);
    end

    write_timeout('1);
    run_random(35);
    write_timeout(CountW'(3));
    run_random(35);
    write_timeout(CountW'(1));
    run_random(20);
    quiet = 1'b1;
    write_timeout(CountW'(2));
    run_random(40);

    drain_results();
    if (!failed)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
sv/i2c_rts_pkg.sv
sv/i2c_rts_channels.sv
sv/i2c_rts_step.sv
sv/i2c_rts_drain.sv
sv/i2c_register_transfer_sequencer_unit.sv
verif/i2c_register_transfer_sequencer_unit_tb.sv
